### rtl/version_string_api_check_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the version check block
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef VERSION_STRING_API_CHECK_MACROS_SVH
`define VERSION_STRING_API_CHECK_MACROS_SVH

// Same-cycle implication
`define VSAC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define VSAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/vsac_pkg.sv
// ----------------------------------------------------------------------------
// vsac_pkg
// Types and constants shared by the version string check modules.
// ----------------------------------------------------------------------------
package vsac_pkg;

	// Default string buffer size, terminator included
	localparam int MAX_STRING_BYTES_DEF = 64;

	localparam int SEG_W    = 7;
	localparam int IN_DW    = 40;
	localparam int OUT_DW   = 24;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 32;
	localparam int PK_W     = 20;

	// Parser phases
	typedef enum logic [3:0] {
		PH_MAJ_FIRST = 4'd0,
		PH_MAJ       = 4'd1,
		PH_MIN_FIRST = 4'd2,
		PH_MIN       = 4'd3,
		PH_PAT_FIRST = 4'd4,
		PH_PAT       = 4'd5,
		PH_SUF_FIRST = 4'd6,
		PH_SUF       = 4'd7,
		PH_END       = 4'd8,
		PH_BAD       = 4'd9
	} phase_t;

	// Configuration register indexes
	typedef enum logic [CFG_IW-1:0] {
		REG_USE_DIST  = 3'd0,
		REG_PACKED    = 3'd1,
		REG_SDK_MAJOR = 3'd2,
		REG_SDK_MINOR = 3'd3,
		REG_SDK_PATCH = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic               use_dist;
		logic signed [31:0] packed_ver;
		logic [15:0]        sdk_major;
		logic [15:0]        sdk_minor;
		logic [15:0]        sdk_patch;
	} cfg_t;

	// Finished request handed from parser to compare stage
	typedef struct packed {
		logic             done;
		logic             ok;
		logic [SEG_W-1:0] maj;
		logic [SEG_W-1:0] minor;
		logic [SEG_W-1:0] pat;
	} req_t;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [SEG_W-1:0] SEG_MAX     = 7'd99;
	localparam logic signed [31:0] NUM_MAX   = 32'sd99;
	localparam logic signed [31:0] PACK_MIN  = 32'sd10000;
	localparam logic signed [31:0] PACK_MAX  = 32'sd999999;
	localparam logic [PK_W-1:0]  MUL_MAJ     = 20'd10000;
	localparam logic [PK_W-1:0]  MUL_MIN     = 20'd100;

endpackage

### rtl/version_string_api_check.sv
// ----------------------------------------------------------------------------
// version_string_api_check
// Checks a requested version, streamed as characters or given as a number,
// against the configured system version.
// ----------------------------------------------------------------------------
//  channel | signals                          | carries
//  --------+----------------------------------+-------------------------------
//  s       | s_tvalid s_tready s_tdata s_tuser | one character or numeric major
//  m       | m_tvalid m_tready m_tdata         | one result per finished request
//  cfg     | cfg_valid cfg_ready cfg_index     | register writes, always ready
//          | cfg_data                         |
//
// One request per cycle is accepted while s_tready is high; a request that
// finishes passes the input register, then parse and compare into the
// result register. The parser state update is a registered loop.
// Reset clears the parser, the configuration registers and both valid flags.
// A stalled result holds m_tdata; requests that give no result keep flowing
// while it waits, and a finishing request waits in the input register.
// ----------------------------------------------------------------------------
module version_string_api_check import vsac_pkg::*; #(
	parameter int MAX_STRING_BYTES = MAX_STRING_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,   // [7:0] ch, [39:8] number_major
	input  logic [0:0]        s_tuser,   // [0] req_type
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,   // [0] available, [1] format_valid,
	                                     // [8:2] req_major, [15:9] req_minor,
	                                     // [22:16] req_patch, [23] zero
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	logic               v_s1;
	logic               type_s1;
	logic [7:0]         ch_s1;
	logic signed [31:0] num_s1;
	cfg_t               cfg_q;
	req_t               req;
	logic               out_free;
	logic               adv;

	// Advance the input stage when its request needs no slot or one is free
	assign out_free  = !m_tvalid || m_tready;
	assign adv       = v_s1 && (!req.done || out_free);
	assign s_tready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			type_s1 <= s_tuser[0];
			ch_s1   <= s_tdata[7:0];
			num_s1  <= s_tdata[39:8];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_USE_DIST:  cfg_q.use_dist   <= cfg_data[0];
				REG_PACKED:    cfg_q.packed_ver <= cfg_data;
				REG_SDK_MAJOR: cfg_q.sdk_major  <= cfg_data[15:0];
				REG_SDK_MINOR: cfg_q.sdk_minor  <= cfg_data[15:0];
				REG_SDK_PATCH: cfg_q.sdk_patch  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	vsac_parse #(
		.MAX_STRING_BYTES(MAX_STRING_BYTES)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.req_type     (type_s1),
		.ch           (ch_s1),
		.number_major (num_s1),
		.req          (req)
	);

	vsac_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req      (req),
		.load     (adv && req.done),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

### rtl/vsac_parse.sv
// ----------------------------------------------------------------------------
// vsac_parse
// Character-serial parser of N.N.N(M) strings and numeric major requests.
// ----------------------------------------------------------------------------
module vsac_parse import vsac_pkg::*; #(
	parameter int MAX_STRING_BYTES = MAX_STRING_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               req_type,
	input  logic [7:0]         ch,
	input  logic signed [31:0] number_major,
	output req_t               req
);

	localparam int CNT_W = $clog2(MAX_STRING_BYTES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_STRING_BYTES - 1);

	phase_t           phase_q, phase_n;
	logic [SEG_W-1:0] seg_q, seg_n;
	logic [SEG_W-1:0] maj_q, maj_n;
	logic [SEG_W-1:0] min_q, min_n;
	logic [SEG_W-1:0] pat_q, pat_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;

	logic       is_dig;
	logic [9:0] acc;
	logic       num_ok;
	logic       str_ok;

	assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign acc    = {3'b000, seg_q} * 10'd10 + {6'b000000, ch[3:0]};
	assign num_ok = (number_major > 32'sd0) && (number_major <= NUM_MAX);
	assign str_ok = ((phase_q == PH_PAT) || (phase_q == PH_END)) && (maj_q != '0);

	// Next parser state and finished request
	always_comb begin
		phase_n = phase_q;
		seg_n   = seg_q;
		maj_n   = maj_q;
		min_n   = min_q;
		pat_n   = pat_q;
		cnt_n   = cnt_q;
		req     = '0;
		if (req_type) begin
			req.done = 1'b1;
			req.ok   = num_ok;
			req.maj  = num_ok ? number_major[SEG_W-1:0] : '0;
			phase_n  = PH_MAJ_FIRST;
			seg_n    = '0;
			maj_n    = '0;
			min_n    = '0;
			pat_n    = '0;
			cnt_n    = '0;
		end else if (ch == CH_NUL) begin
			req.done  = 1'b1;
			req.ok    = str_ok;
			req.maj   = str_ok ? maj_q : '0;
			req.minor = str_ok ? min_q : '0;
			req.pat   = !str_ok ? '0 : ((phase_q == PH_PAT) ? seg_q : pat_q);
			phase_n   = PH_MAJ_FIRST;
			seg_n     = '0;
			maj_n     = '0;
			min_n     = '0;
			pat_n     = '0;
			cnt_n     = '0;
		end else if (cnt_q < CNT_LAST) begin
			cnt_n = cnt_q + 1'b1;
			unique case (phase_q)
				PH_MAJ_FIRST, PH_MIN_FIRST, PH_PAT_FIRST, PH_SUF_FIRST: begin
					if (is_dig) begin
						seg_n   = {3'b000, ch[3:0]};
						phase_n = phase_t'(phase_q + 4'd1);
					end else begin
						phase_n = PH_BAD;
					end
				end
				PH_MAJ, PH_MIN, PH_PAT, PH_SUF: begin
					priority if (is_dig) begin
						seg_n = acc[SEG_W-1:0];
						if (acc > {3'b000, SEG_MAX}) begin
							phase_n = PH_BAD;
						end
					end else if (phase_q == PH_MAJ && ch == CH_DOT) begin
						maj_n   = seg_q;
						phase_n = PH_MIN_FIRST;
					end else if (phase_q == PH_MIN && ch == CH_DOT) begin
						min_n   = seg_q;
						phase_n = PH_PAT_FIRST;
					end else if (phase_q == PH_PAT && ch == CH_LPAR) begin
						pat_n   = seg_q;
						phase_n = PH_SUF_FIRST;
					end else if (phase_q == PH_SUF && ch == CH_RPAR) begin
						phase_n = PH_END;
					end else begin
						phase_n = PH_BAD;
					end
				end
				default: begin
					phase_n = PH_BAD;
				end
			endcase
		end
	end

	// Advance parser state on each consumed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAJ_FIRST;
			seg_q   <= '0;
			maj_q   <= '0;
			min_q   <= '0;
			pat_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			seg_q   <= seg_n;
			maj_q   <= maj_n;
			min_q   <= min_n;
			pat_q   <= pat_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

### rtl/vsac_out.sv
// ----------------------------------------------------------------------------
// vsac_out
// Compares a finished request with the system version; holds the result.
// ----------------------------------------------------------------------------
module vsac_out import vsac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  req_t              req,
	input  logic              load,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [OUT_DW-1:0] m_tdata
);

	logic [PK_W-1:0] req_pk;
	logic [PK_W-1:0] sys_pk;
	logic            pack_ok;
	logic            ge_pk;
	logic            ge_sdk;
	logic            avail;
	logic [15:0]     maj16, min16, pat16;

	// Both sides pack as base-100 digits, so a plain compare orders them
	assign req_pk  = {13'b0, req.maj} * MUL_MAJ + {13'b0, req.minor} * MUL_MIN
		+ {13'b0, req.pat};
	assign sys_pk  = cfg.packed_ver[PK_W-1:0];
	assign pack_ok = cfg.use_dist && (cfg.packed_ver >= PACK_MIN)
		&& (cfg.packed_ver <= PACK_MAX);
	assign ge_pk   = sys_pk >= req_pk;

	assign maj16  = {9'b0, req.maj};
	assign min16  = {9'b0, req.minor};
	assign pat16  = {9'b0, req.pat};
	assign ge_sdk = (cfg.sdk_major != maj16) ? (cfg.sdk_major > maj16) :
		(cfg.sdk_minor != min16) ? (cfg.sdk_minor > min16) :
		(cfg.sdk_patch >= pat16);

	assign avail = req.ok && (pack_ok ? ge_pk : ge_sdk);

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {1'b0, req.pat, req.minor, req.maj, req.ok, avail};
		end
	end

endmodule

### rtl/vsac_check.sv
// ----------------------------------------------------------------------------
// vsac_check
// Port-level checks on the result stream of the version check block.
// ----------------------------------------------------------------------------
`include "version_string_api_check_macros.svh"

module vsac_check import vsac_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_DW-1:0] m_tdata
);

	// Invalid requests carry an all-zero result
	`VSAC_ASSERT_IMPLY(a_invalid_zero, m_tvalid && !m_tdata[1], m_tdata == '0, "invalid result not zero")

	// Availability only for a well-formed request
	`VSAC_ASSERT_IMPLY(a_avail_valid, m_tvalid && m_tdata[0], m_tdata[1], "available without format_valid")

	// Valid request segments stay in range
	`VSAC_ASSERT_IMPLY(a_seg_range, m_tvalid && m_tdata[1], (m_tdata[8:2] != 7'd0) && (m_tdata[8:2] <= SEG_MAX) && (m_tdata[15:9] <= SEG_MAX) && (m_tdata[22:16] <= SEG_MAX) && !m_tdata[23], "segment out of range")

	// Stalled result holds
	`VSAC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind version_string_api_check vsac_check u_check (.*);
